### src/fcf_pkg.sv
`default_nettype none
package fcf_pkg;

	// Width of the frame length field taken from the frame header.
	localparam int LEN_BITS = 10;
	// Width of the chunk_limit register.
	localparam int LIMIT_BITS = 10;
	// Width used to compare a frame length against the chunk limit.
	localparam int CMP_BITS = (LEN_BITS > LIMIT_BITS) ? LEN_BITS : LIMIT_BITS;

	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(251);
	localparam logic [15:0] CHUNK_FLAG = 16'h0400;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [1:0] KIND_HDR  = 2'd0;
	localparam logic [1:0] KIND_DATA = 2'd1;
	localparam logic [1:0] KIND_CRC  = 2'd2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

	// One unit of work handed from the front end to the back end.
	typedef struct packed {
		logic        hdr_en;
		logic [15:0] hdr;
		logic        data_en;
		logic [7:0]  data;
		logic        crc_en;
	} job_t;

	// CRC-16/CCITT-FALSE over one byte, MSB first.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

### src/fcf_in_if.sv
`default_nettype none
interface fcf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] image_byte;

	modport source (output valid, output image_byte, input ready);
	modport sink (input valid, input image_byte, output ready);
endinterface
`default_nettype wire

### src/fcf_out_if.sv
`default_nettype none
interface fcf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] byte_kind;
	logic       chunk_end;
	logic       last_result;

	modport source (output valid, output out_byte, output byte_kind, output chunk_end,
		output last_result, input ready);
	modport sink (input valid, input out_byte, input byte_kind, input chunk_end,
		input last_result, output ready);
endinterface
`default_nettype wire

### src/fcf_cfg_if.sv
`default_nettype none
interface fcf_cfg_if;
	logic       valid;
	logic       ready;
	logic [9:0] chunk_limit;

	modport source (output valid, output chunk_limit, input ready);
	modport sink (input valid, input chunk_limit, output ready);
endinterface
`default_nettype wire

### src/fcf_front.sv
`default_nettype none
module fcf_front
	import fcf_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	fcf_in_if.sink    image,
	fcf_cfg_if.sink   cfg,
	input  wire logic q_full,
	output logic      push,
	output job_t      push_job
);

	localparam logic [1:0] PH_HDR_HI  = 2'd0;
	localparam logic [1:0] PH_HDR_LO  = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;

	logic [1:0]            phase_q;
	logic [7:0]            hdr_hi_q;
	logic [LEN_BITS-1:0]   frame_left_q;
	logic [LEN_BITS-1:0]   chunk_left_q;
	logic [LIMIT_BITS-1:0] limit_q;

	logic                  accept;
	logic [LEN_BITS-1:0]   hdr_len;
	logic [LIMIT_BITS-1:0] lim;
	logic                  more;
	logic                  new_chunk;
	logic [LEN_BITS-1:0]   cl_new;
	logic [LEN_BITS-1:0]   cl_after;
	logic [LEN_BITS-1:0]   fl_after;

	assign cfg.ready   = 1'b1;
	assign image.ready = !q_full;
	assign accept      = image.valid && !q_full;

	assign hdr_len   = LEN_BITS'({hdr_hi_q, image.image_byte});
	assign lim       = (limit_q == '0) ? LIMIT_BITS'(1) : limit_q;
	assign more      = CMP_BITS'(frame_left_q) > CMP_BITS'(lim);
	assign new_chunk = (chunk_left_q == '0);
	// When the limit wins it is below the frame length, so it fits the length width.
	assign cl_new    = more ? LEN_BITS'(lim) : frame_left_q;
	assign cl_after  = (new_chunk ? cl_new : chunk_left_q) - LEN_BITS'(1);
	assign fl_after  = frame_left_q - LEN_BITS'(1);

	always_comb begin
		push     = 1'b0;
		push_job = '0;
		case (phase_q)
			PH_HDR_LO: begin
				if (hdr_len == '0) begin
					push            = accept;
					push_job.hdr_en = 1'b1;
					push_job.crc_en = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				push             = accept;
				push_job.hdr_en  = new_chunk;
				push_job.hdr     = (more ? CHUNK_FLAG : 16'h0000) | 16'(cl_new);
				push_job.data_en = 1'b1;
				push_job.data    = image.image_byte;
				push_job.crc_en  = (cl_after == '0);
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg.valid) begin
			limit_q <= cfg.chunk_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HDR_HI;
			hdr_hi_q     <= '0;
			frame_left_q <= '0;
			chunk_left_q <= '0;
		end else if (accept) begin
			case (phase_q)
				PH_HDR_HI: begin
					hdr_hi_q <= image.image_byte;
					phase_q  <= PH_HDR_LO;
				end
				PH_HDR_LO: begin
					frame_left_q <= hdr_len;
					chunk_left_q <= '0;
					phase_q      <= (hdr_len == '0) ? PH_HDR_HI : PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					chunk_left_q <= cl_after;
					frame_left_q <= fl_after;
					if (cl_after == '0 && fl_after == '0) begin
						phase_q <= PH_HDR_HI;
					end
				end
				default: begin
					phase_q <= PH_HDR_HI;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### src/fcf_queue.sv
`default_nettype none
module fcf_queue
	import fcf_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      push_job,
	input  wire logic pop,
	output logic      full,
	output logic      head_valid,
	output job_t      head_job
);

	job_t                 slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;

	assign full       = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_BITS+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_BITS+1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

### src/fcf_back.sv
`default_nettype none
module fcf_back
	import fcf_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic head_valid,
	input  job_t      head_job,
	output logic      pop,
	fcf_out_if.source chunk
);

	localparam logic [2:0] ST_HDR_HI = 3'd0;
	localparam logic [2:0] ST_HDR_LO = 3'd1;
	localparam logic [2:0] ST_DATA   = 3'd2;
	localparam logic [2:0] ST_CRC_HI = 3'd3;
	localparam logic [2:0] ST_CRC_LO = 3'd4;

	logic        started_q;
	logic [2:0]  step_q;
	logic [15:0] crc_q;
	logic        valid_q;
	logic [7:0]  byte_q;
	logic [1:0]  kind_q;
	logic        end_q;
	logic        last_q;

	logic        load;
	logic [2:0]  first_step;
	logic [2:0]  cur_step;
	logic [2:0]  next_step;
	logic        is_last;
	logic [7:0]  cur_byte;
	logic [1:0]  cur_kind;
	logic [15:0] crc_next;

	assign first_step = head_job.hdr_en ? ST_HDR_HI : (head_job.data_en ? ST_DATA : ST_CRC_HI);
	assign cur_step   = started_q ? step_q : first_step;
	assign load       = head_valid && (!valid_q || chunk.ready);
	assign pop        = load && is_last;

	always_comb begin
		next_step = ST_CRC_LO;
		is_last   = 1'b0;
		cur_byte  = head_job.data;
		cur_kind  = KIND_DATA;
		crc_next  = crc_q;
		case (cur_step)
			ST_HDR_HI: begin
				next_step = ST_HDR_LO;
				cur_byte  = head_job.hdr[15:8];
				cur_kind  = KIND_HDR;
				crc_next  = crc_byte(CRC_INIT, head_job.hdr[15:8]);
			end
			ST_HDR_LO: begin
				cur_byte = head_job.hdr[7:0];
				cur_kind = KIND_HDR;
				crc_next = crc_byte(crc_q, head_job.hdr[7:0]);
				if (head_job.data_en) begin
					next_step = ST_DATA;
				end else if (head_job.crc_en) begin
					next_step = ST_CRC_HI;
				end else begin
					is_last = 1'b1;
				end
			end
			ST_DATA: begin
				crc_next = crc_byte(crc_q, head_job.data);
				if (head_job.crc_en) begin
					next_step = ST_CRC_HI;
				end else begin
					is_last = 1'b1;
				end
			end
			ST_CRC_HI: begin
				next_step = ST_CRC_LO;
				cur_byte  = crc_q[15:8];
				cur_kind  = KIND_CRC;
			end
			default: begin
				is_last  = 1'b1;
				cur_byte = crc_q[7:0];
				cur_kind = KIND_CRC;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			step_q    <= ST_HDR_HI;
			crc_q     <= CRC_INIT;
			valid_q   <= 1'b0;
		end else begin
			if (load) begin
				started_q <= !is_last;
				step_q    <= next_step;
				crc_q     <= crc_next;
				valid_q   <= 1'b1;
			end else if (chunk.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= cur_byte;
			kind_q <= cur_kind;
			end_q  <= (cur_step == ST_CRC_LO);
			last_q <= is_last;
		end
	end

	assign chunk.valid       = valid_q;
	assign chunk.out_byte    = byte_q;
	assign chunk.byte_kind   = kind_q;
	assign chunk.chunk_end   = end_q;
	assign chunk.last_result = last_q;

endmodule
`default_nettype wire

### src/firmware_chunk_framer_crc16.sv
// Firmware chunk framer. Image bytes enter on the image channel, one per
// transaction. Every frame starts with a two-byte big-endian header whose low
// ten bits give the payload length; the header produces no output unless the
// length is zero. The payload leaves on the chunk channel split into chunks of
// at most chunk_limit bytes, each sent as a two-byte header (0x0400 flag set
// when more chunks of the frame follow), the data bytes and a two-byte
// CRC-16/CCITT-FALSE over header and data. One input transaction produces
// zero to five output transactions; last_result marks the final one.
// The cfg channel writes chunk_limit (reset value 251, zero acts as one) and
// is always ready; write it only while the block is idle.
// The front end takes one image byte per cycle, unless the queue is full, and
// posts a work entry into a four-entry queue; the back end drains that queue
// at one output byte per cycle while the receiver is ready, through a
// registered output stage. Sustained rate is one byte per cycle, set by the
// single output byte lane; chunk edges add up to four extra bytes that the
// queue absorbs, and image.ready drops only while it is full. When the
// receiver stalls, the output register holds its byte, the queue fills and
// then input is back-pressured. Reset clears all parsing state and the queue,
// and returns chunk_limit to 251.
`default_nettype none
module firmware_chunk_framer_crc16
	import fcf_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	fcf_in_if.sink    image,
	fcf_cfg_if.sink   cfg,
	fcf_out_if.source chunk
);

	logic q_full;
	logic push;
	job_t push_job;
	logic pop;
	logic head_valid;
	job_t head_job;

	// Front end: header parsing, chunk splitting and work classification.
	fcf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.image    (image),
		.cfg      (cfg),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	// Work queue that decouples input acceptance from output bursts.
	fcf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// Back end: byte serializer with the running CRC.
	fcf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.chunk      (chunk)
	);

endmodule
`default_nettype wire
